[hdl/crsf_frame_receiver_defines.svh]
// Assertion macros shared by the frame receiver RTL.
`ifndef CRSF_FRAME_RECEIVER_DEFINES_SVH
`define CRSF_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CRSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/crsf_pkg.sv]
// Constants and register indexes for the frame receiver.
package crsf_pkg;

  // Frame store depth and derived widths
  localparam int unsigned FrameBytes = 64;
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  localparam int unsigned FillW      = $clog2(FrameBytes + 1);

  // Length byte rules
  localparam int unsigned LenW     = 6;
  localparam int unsigned EndW     = LenW + 1;
  localparam int unsigned CmpW     = (FillW > EndW) ? FillW : EndW;
  localparam logic [7:0]  LenMin   = 8'd2;
  localparam logic [7:0]  LenMax   = 8'd62;
  localparam int unsigned HdrBytes = 2;
  localparam int unsigned PayOff   = 3;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgSyncMask0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncMask1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSyncMask2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSyncMask3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCrcPoly   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [63:0] SyncMask0Rst = 64'd1;
  localparam logic [63:0] SyncMask3Rst = 64'd92358976733440;
  localparam logic [7:0]  CrcPolyRst   = 8'hD5;

endpackage

[hdl/crsf_frame_receiver.sv]
// Byte-serial frame receiver: sync hunt, length check, CRC-8, payload output.
// Usage:
//  - Input channel (in_valid_i / in_stall_o / rx_byte_i) takes one received
//    byte per item. in_stall_o is high whenever the block is busy.
//  - Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
//    writes sync_mask_0..3 (indexes 0..3) and crc_poly (index 4); other
//    indexes are ignored. Write only while the block is idle.
//  - Output channel (out_valid_o / out_stall_i) gives one result per payload
//    byte of a frame whose CRC matched, or one result for an empty payload.
// Timing:
//  - Start, length and closing bytes are taken without a CRC step. Type and
//    payload bytes are taken, then pass through 8 steps of the bit-serial CRC unit.
//  - A good closing byte starts the output walk: each payload result passes
//    through a registered frame store read, then the output state; an empty
//    payload goes straight to the output state.
//  - While out_stall_i is high the result holds and no byte is taken.
// Reset returns to sync hunt and restores the register defaults. The frame
// store has no clear; only entries written for the current frame are read.
module crsf_frame_receiver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Config write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [crsf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                  cfg_data_i,
  // Byte input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   frame_address_o,
  output logic [crsf_pkg::LenW-1:0]    frame_length_o,
  output logic [7:0]                   frame_type_o,
  output logic [crsf_pkg::LenW-1:0]    payload_count_o,
  output logic                         payload_present_o,
  output logic [crsf_pkg::LenW-1:0]    payload_index_o,
  output logic [7:0]                   payload_byte_o,
  output logic                         last_o
);
  import crsf_pkg::*;

  `include "crsf_frame_receiver_defines.svh"

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCrc  = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]        state_q;
  logic [FillW-1:0]  fill_q;
  logic [7:0]        crc_q;
  logic [2:0]        bit_cnt_q;
  logic [LenW-1:0]   k_q;
  logic [63:0]       sync_mask_q [4];
  logic [7:0]        crc_poly_q;

  logic [7:0]        addr_q;
  logic [LenW-1:0]   len_q;
  logic [7:0]        type_q;
  logic [7:0]        rd_q;
  logic [7:0]        store_mem [FrameBytes];

  logic              in_acc;
  logic              start_hit;
  logic              len_ok;
  logic [FillW-1:0]  fill_inc;
  logic [EndW-1:0]   frame_end;
  logic              is_close;
  logic              store_full;
  logic              store_wr;
  logic [LenW-1:0]   pay_cnt;
  logic              pay_any;
  logic              is_last;
  logic [IdxW-1:0]   rd_addr;
  logic [7:0]        crc_shl;

  // Decode of the incoming byte against the frame position
  always_comb begin
    in_acc     = in_valid_i && (state_q == StIdle);
    start_hit  = sync_mask_q[rx_byte_i[7:6]][rx_byte_i[5:0]];
    len_ok     = (rx_byte_i >= LenMin) && (rx_byte_i <= LenMax);
    fill_inc   = fill_q + FillW'(1);
    frame_end  = EndW'(len_q) + EndW'(HdrBytes);
    is_close   = (CmpW'(fill_inc) == CmpW'(frame_end));
    store_full = (fill_q >= FillW'(FrameBytes));
    store_wr   = in_acc && (fill_q >= FillW'(HdrBytes)) && !store_full;
    pay_cnt    = len_q - LenW'(HdrBytes);
    pay_any    = (pay_cnt != '0);
    is_last    = ((EndW'(k_q) + EndW'(1)) >= EndW'(pay_cnt));
    rd_addr    = IdxW'(32'(k_q) + 32'(PayOff));
    crc_shl    = {crc_q[6:0], 1'b0};
  end

  // Control: sequencer, fill count, CRC unit, output walk, config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      fill_q         <= '0;
      crc_q          <= '0;
      bit_cnt_q      <= '0;
      k_q            <= '0;
      sync_mask_q[0] <= SyncMask0Rst;
      sync_mask_q[1] <= '0;
      sync_mask_q[2] <= '0;
      sync_mask_q[3] <= SyncMask3Rst;
      crc_poly_q     <= CrcPolyRst;
    end else begin
      // config writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgSyncMask0: sync_mask_q[0] <= cfg_data_i;
          CfgSyncMask1: sync_mask_q[1] <= cfg_data_i;
          CfgSyncMask2: sync_mask_q[2] <= cfg_data_i;
          CfgSyncMask3: sync_mask_q[3] <= cfg_data_i;
          CfgCrcPoly:   crc_poly_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (fill_q == '0) begin
              if (start_hit) fill_q <= FillW'(1);
            end else if (fill_q == FillW'(1)) begin
              if (!len_ok) begin
                // bad length: the same byte may open a new candidate
                fill_q <= start_hit ? FillW'(1) : '0;
              end else begin
                fill_q <= FillW'(HdrBytes);
                crc_q  <= '0;
              end
            end else if (store_full) begin
              fill_q <= '0;
            end else if (!is_close) begin
              fill_q    <= fill_inc;
              crc_q     <= crc_q ^ rx_byte_i;
              bit_cnt_q <= '0;
              state_q   <= StCrc;
            end else begin
              fill_q <= '0;
              if (rx_byte_i == crc_q) begin
                k_q     <= '0;
                state_q <= pay_any ? StRead : StEmit;
              end
            end
          end
        end
        StCrc: begin
          // one polynomial step per cycle, MSB first
          crc_q     <= crc_q[7] ? (crc_shl ^ crc_poly_q) : crc_shl;
          bit_cnt_q <= bit_cnt_q + 3'd1;
          if (bit_cnt_q == 3'd7) state_q <= StIdle;
        end
        StRead: begin
          state_q <= StEmit;
        end
        StEmit: begin
          if (!out_stall_i) begin
            if (is_last) begin
              state_q <= StIdle;
            end else begin
              k_q     <= k_q + LenW'(1);
              state_q <= StRead;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Header capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if ((fill_q == '0) && start_hit) addr_q <= rx_byte_i;
      if ((fill_q == FillW'(1)) && !len_ok && start_hit) addr_q <= rx_byte_i;
      if ((fill_q == FillW'(1)) && len_ok) len_q <= rx_byte_i[LenW-1:0];
      if (fill_q == FillW'(HdrBytes)) type_q <= rx_byte_i;
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_wr) store_mem[fill_q[IdxW-1:0]] <= rx_byte_i;
    if (state_q == StRead) rd_q <= store_mem[rd_addr];
  end

  // Ports
  assign cfg_ready_o       = 1'b1;
  assign in_stall_o        = (state_q != StIdle);
  assign out_valid_o       = (state_q == StEmit);
  assign frame_address_o   = addr_q;
  assign frame_length_o    = len_q;
  assign frame_type_o      = type_q;
  assign payload_count_o   = pay_cnt;
  assign payload_present_o = pay_any;
  assign payload_index_o   = k_q;
  assign payload_byte_o    = pay_any ? rd_q : 8'd0;
  assign last_o            = is_last;

  // Checks
  `CRSF_ASSERT_NOW(a_no_input_while_out, out_valid_o, in_stall_o, "byte taken during output")
  `CRSF_ASSERT_NOW(a_crc_mid_frame, state_q == StCrc, fill_q > FillW'(HdrBytes), "CRC step outside frame body")
  `CRSF_ASSERT_NOW(a_index_in_payload, out_valid_o && payload_present_o, payload_index_o < payload_count_o, "payload index out of range")
  `CRSF_ASSERT_NEXT(a_last_to_hunt, out_valid_o && !out_stall_i && last_o, (state_q == StIdle) && (fill_q == '0), "no return to hunt after last result")

endmodule
